/* rtl/gspa_pkg.sv */
`timescale 1ns / 1ps

package gspa_pkg;

    // running sums and divider datapath
    localparam int SUM_W   = 32;
    localparam int HOLD_W  = 16;
    localparam int INDEX_W = 8;
    localparam int EVENT_W = 3;
    localparam int PC_W    = 3;

    // status byte masks
    localparam logic [7:0] ST_INVALID_MODE = 8'h40;
    localparam logic [7:0] ST_INVALID_OUT  = 8'h0c;
    localparam logic [7:0] ST_NEW_DATA     = 8'h82;

    localparam logic [INDEX_W-1:0] FAN_LEVEL = 8'd3;

    // event codes
    localparam logic [EVENT_W-1:0] EV_STARTED     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_REINIT      = 3'd1;
    localparam logic [EVENT_W-1:0] EV_INVALID_OUT = 3'd2;
    localparam logic [EVENT_W-1:0] EV_NO_DATA     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_NEW_DATA    = 3'd4;

    // register map
    localparam logic REG_AVG_ENABLE = 1'b0;

    // microprogram step addresses
    localparam logic [PC_W-1:0] STEP_WAIT     = 3'd0;
    localparam logic [PC_W-1:0] STEP_CLASSIFY = 3'd1;
    localparam logic [PC_W-1:0] STEP_ADD      = 3'd2;
    localparam logic [PC_W-1:0] STEP_SHIFT    = 3'd3;
    localparam logic [PC_W-1:0] STEP_DIV_GO   = 3'd4;
    localparam logic [PC_W-1:0] STEP_DIV_WAIT = 3'd5;
    localparam logic [PC_W-1:0] STEP_EMIT     = 3'd6;
    localparam logic [PC_W-1:0] STEP_RETURN   = 3'd7;

    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_ACCEPT    = 3'd1,
        OP_CLASSIFY  = 3'd2,
        OP_ADD       = 3'd3,
        OP_SHIFT     = 3'd4,
        OP_DIV_START = 3'd5,
        OP_DIV_STORE = 3'd6,
        OP_EMIT      = 3'd7
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_INPUT = 3'd2,
        C_SKIP_AVG = 3'd3,
        C_WARMUP   = 3'd4,
        C_DIV_BUSY = 3'd5,
        C_OUT_BUSY = 3'd6
    } ucond_t;

    typedef struct packed {
        uop_t            op;
        ucond_t          cond;
        logic [PC_W-1:0] target;
    } uword_t;

    // control store: jump to target when cond holds, else fall through
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] step);
        uword_t w;
        begin
            unique case (step)
                STEP_WAIT:     w = '{OP_ACCEPT,    C_NO_INPUT, STEP_WAIT};
                STEP_CLASSIFY: w = '{OP_CLASSIFY,  C_SKIP_AVG, STEP_EMIT};
                STEP_ADD:      w = '{OP_ADD,       C_WARMUP,   STEP_DIV_GO};
                STEP_SHIFT:    w = '{OP_SHIFT,     C_ALWAYS,   STEP_EMIT};
                STEP_DIV_GO:   w = '{OP_DIV_START, C_NEVER,    STEP_DIV_WAIT};
                STEP_DIV_WAIT: w = '{OP_DIV_STORE, C_DIV_BUSY, STEP_DIV_WAIT};
                STEP_EMIT:     w = '{OP_EMIT,      C_OUT_BUSY, STEP_EMIT};
                STEP_RETURN:   w = '{OP_NOP,       C_ALWAYS,   STEP_WAIT};
                default:       w = '{OP_NOP,       C_ALWAYS,   STEP_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

/* rtl/gspa_div.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module gspa_div
    import gspa_pkg::*;
#(
    parameter int DIV_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [SUM_W-1:0] quotient
);

    localparam int BIT_CNT_W = $clog2(SUM_W);

    logic                 busy_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     div_reg;

    logic [DIV_W:0]       trial;
    logic                 fits;
    logic [DIV_W-1:0]     rem_next;

    always_comb begin
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end else if (start) begin
            busy_reg    <= 1'b1;
            bit_cnt_reg <= BIT_CNT_W'(SUM_W - 1);
        end else if (busy_reg) begin
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
            if (bit_cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/gas_sensor_poll_averager.sv */
`timescale 1ns / 1ps

// gas sensor poll averager: every accepted poll (status byte in s_tuser, air index, tvoc and
// eco2 readings in s_tdata) yields exactly one result transaction carrying the event kind and
// the held averages, index and fan flag. the first poll after reset, or after an invalid-mode
// status, only switches the device model to standard mode. on new data with averaging enabled
// eco2 and tvoc feed running sums: a plain mean while fewer than 2**AVG_SHIFT samples were
// taken, then an exponential average (sum >> AVG_SHIFT, subtracted back from the sum).
// averages saturate at 65535. a small microprogram steps a shared datapath; during warm-up
// two 32-step serial dividers (one per channel, one quotient bit per cycle) form the mean,
// and a stalled result transaction holds the program in its emit step. the averaging_enable
// register sits at byte address 0 of the apb port; write it only while the block is idle
module gas_sensor_poll_averager
    import gspa_pkg::*;
#(
    parameter int AVG_SHIFT = 5
) (
    input  logic        aclk,
    input  logic        aresetn,

    // poll input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // air_index[7:0], tvoc_raw[23:8], eco2_raw[39:24]
    input  logic [7:0]  s_tuser,   // status_byte[7:0]

    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // eco2_avg[15:0], tvoc_avg[31:16], index_out[39:32],
                                   // fan_on[40], zero fill[47:41]
    output logic [2:0]  m_tuser,   // event_kind[2:0]

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = AVG_SHIFT + 1;
    localparam int LIMIT = 1 << AVG_SHIFT;

    // sequencer
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          uw;
    logic            jump;

    // latched poll
    logic [7:0]        status_reg;
    logic [INDEX_W-1:0] aqi_reg;
    logic [HOLD_W-1:0] tvoc_in_reg;
    logic [HOLD_W-1:0] eco2_in_reg;

    // block state
    logic               avg_en_reg;
    logic               op_mode_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   eco2_sum_reg;
    logic [SUM_W-1:0]   voc_total_reg;
    logic [HOLD_W-1:0]  eco2_hold_reg;
    logic [HOLD_W-1:0]  tvoc_hold_reg;
    logic [INDEX_W-1:0] index_hold_reg;
    logic [EVENT_W-1:0] event_reg;

    // output register
    logic               m_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [HOLD_W-1:0]  out_eco2_reg;
    logic [HOLD_W-1:0]  out_tvoc_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic               out_fan_reg;

    // datapath helpers
    logic               in_accept;
    logic               out_busy;
    logic               out_load;
    logic               cfg_write;
    logic [EVENT_W-1:0] event_next;
    logic               new_data;
    logic [SUM_W-1:0]   eco2_shr;
    logic [SUM_W-1:0]   tvoc_shr;
    logic               div_start;
    logic               eco2_div_busy;
    logic               tvoc_div_busy;
    logic               div_busy;
    logic [SUM_W-1:0]   eco2_quo;
    logic [SUM_W-1:0]   tvoc_quo;

    function automatic logic [HOLD_W-1:0] sat16(input logic [SUM_W-1:0] v);
        begin
            return (v[SUM_W-1:HOLD_W] != '0) ? {HOLD_W{1'b1}} : v[HOLD_W-1:0];
        end
    endfunction

    // status classification, priority order: reset mode, invalid mode, invalid output, new data
    always_comb begin
        new_data = 1'b0;
        if (!op_mode_reg) begin
            event_next = EV_STARTED;
        end else if ((status_reg & ST_INVALID_MODE) != '0) begin
            event_next = EV_REINIT;
        end else if ((status_reg & ST_INVALID_OUT) == ST_INVALID_OUT) begin
            event_next = EV_INVALID_OUT;
        end else if ((status_reg & ST_NEW_DATA) == ST_NEW_DATA) begin
            event_next = EV_NEW_DATA;
            new_data   = 1'b1;
        end else begin
            event_next = EV_NO_DATA;
        end
    end

    assign uw        = ucode_rom(pc_reg);
    assign s_tready  = (uw.op == OP_ACCEPT);
    assign in_accept = s_tvalid && s_tready;
    assign out_busy  = m_valid_reg && !m_tready;
    assign out_load  = (uw.op == OP_EMIT) && !out_busy;
    assign div_start = (uw.op == OP_DIV_START);
    assign div_busy  = eco2_div_busy || tvoc_div_busy;
    assign eco2_shr  = eco2_sum_reg >> AVG_SHIFT;
    assign tvoc_shr  = voc_total_reg >> AVG_SHIFT;

    // branch condition of the current control word
    always_comb begin
        case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !s_tvalid;
            C_SKIP_AVG: jump = !(new_data && avg_en_reg);
            C_WARMUP:   jump = (count_reg < CNT_W'(LIMIT));
            C_DIV_BUSY: jump = div_busy;
            C_OUT_BUSY: jump = out_busy;
            default:    jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // poll capture
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            aqi_reg     <= s_tdata[7:0];
            tvoc_in_reg <= s_tdata[23:8];
            eco2_in_reg <= s_tdata[39:24];
            status_reg  <= s_tuser;
        end
    end

    // configuration register
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_AVG_ENABLE) ? {31'b0, avg_en_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_en_reg <= 1'b1;
        end else if (cfg_write && (paddr[2] == REG_AVG_ENABLE)) begin
            avg_en_reg <= pwdata[0];
        end
    end

    // datapath driven by the control word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg    <= 1'b0;
            count_reg      <= '0;
            eco2_sum_reg   <= '0;
            voc_total_reg  <= '0;
            eco2_hold_reg  <= '0;
            tvoc_hold_reg  <= '0;
            index_hold_reg <= '0;
            event_reg      <= EV_STARTED;
        end else begin
            case (uw.op)
                OP_CLASSIFY: begin
                    event_reg <= event_next;
                    if (event_next == EV_STARTED) begin
                        op_mode_reg <= 1'b1;
                    end
                    if (event_next == EV_REINIT) begin
                        op_mode_reg <= 1'b0;
                    end
                    if (new_data) begin
                        index_hold_reg <= aqi_reg;
                        if (!avg_en_reg) begin
                            eco2_hold_reg <= eco2_in_reg;
                            tvoc_hold_reg <= tvoc_in_reg;
                        end
                    end
                end
                OP_ADD: begin
                    eco2_sum_reg  <= eco2_sum_reg + SUM_W'(eco2_in_reg);
                    voc_total_reg <= voc_total_reg + SUM_W'(tvoc_in_reg);
                    if (count_reg < CNT_W'(LIMIT)) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_SHIFT: begin
                    // unsaturated average comes back off the sum
                    eco2_sum_reg  <= eco2_sum_reg - eco2_shr;
                    voc_total_reg <= voc_total_reg - tvoc_shr;
                    eco2_hold_reg <= sat16(eco2_shr);
                    tvoc_hold_reg <= sat16(tvoc_shr);
                end
                OP_DIV_STORE: begin
                    if (!div_busy) begin
                        eco2_hold_reg <= sat16(eco2_quo);
                        tvoc_hold_reg <= sat16(tvoc_quo);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // warm-up mean, one divider per channel
    gspa_div #(
        .DIV_W (CNT_W)
    ) u_eco2_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (eco2_sum_reg),
        .divisor  (count_reg),
        .busy     (eco2_div_busy),
        .quotient (eco2_quo)
    );

    gspa_div #(
        .DIV_W (CNT_W)
    ) u_tvoc_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (voc_total_reg),
        .divisor  (count_reg),
        .busy     (tvoc_div_busy),
        .quotient (tvoc_quo)
    );

    // result register, loaded once per poll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_event_reg <= event_reg;
            out_eco2_reg  <= eco2_hold_reg;
            out_tvoc_reg  <= tvoc_hold_reg;
            out_index_reg <= index_hold_reg;
            out_fan_reg   <= (index_hold_reg >= FAN_LEVEL);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {7'b0, out_fan_reg, out_index_reg, out_tvoc_reg, out_eco2_reg};

    // a poll accepted moves straight on to classification
    a_accept_to_classify: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (pc_reg == STEP_CLASSIFY))
        else $error("sequencer did not classify after poll transaction");

    // dividers run only while the program waits on them
    a_div_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (pc_reg == STEP_DIV_WAIT))
        else $error("divider busy outside divide wait step");

    // sample count saturates at the warm-up limit
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIMIT))
        else $error("sample count beyond warm-up limit");

    // a result appears only from the emit step
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(pc_reg) == STEP_EMIT))
        else $error("result transaction raised outside emit step");

    // no poll is taken while one is in flight
    a_single_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (pc_reg == STEP_WAIT) && !div_busy)
        else $error("poll accepted while sequencer busy");

endmodule
